// ===== design/qdd_pkg.sv =====
// shared types, codes and tables for the quadrature detent decoder
`default_nettype none

package qdd_pkg;

   // result direction codes
   typedef enum logic [1:0] {
      TURN_NONE  = 2'd0,
      TURN_LEFT  = 2'd1,
      TURN_RIGHT = 2'd2
   } turn_type;

   // register file geometry and register indexes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_PENDING_LIMIT = 1'b0;
   localparam logic REG_STOP_TICKS    = 1'b1;

   // register reset values
   localparam logic [6:0] PENDING_LIMIT_RESET = 7'd20;
   localparam logic [7:0] STOP_TICKS_RESET    = 8'd60;

   // pin states
   localparam logic [1:0] PINS_REST_HIGH = 2'b11;
   localparam logic [1:0] PINS_REST_LOW  = 2'b00;

   // movement per transition, indexed by {previous pins, current pins}
   localparam logic signed [1:0] STEP_TABLE [16] = '{
      2'sd0, -2'sd1, 2'sd1, 2'sd0,
      2'sd1, 2'sd0, 2'sd0, -2'sd1,
      -2'sd1, 2'sd0, 2'sd0, 2'sd1,
      2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

endpackage

`default_nettype wire

// ===== design/quadrature_detent_decoder.sv =====
// quadrature detent decoder: one encoder sample in, one detent report out
//
// Each transfer on the req_ channel is one sample tick carrying the two encoder
// pin levels and a take request. Each produces exactly one transfer on the rsp_
// channel: the detent taken (none, left, right), the signed pending total after
// the tick, and the half-cycle mode flag.
// The sample lands in an input register; from there the decode logic updates the
// encoder state and loads the result register.
// Throughput is one sample per cycle while rsp_ready holds; the tracking state is updated by a single
// register stage, so back-to-back samples chain without bubbles.
// If the receiver stalls, the result register holds its item and the input
// register still takes one more sample; req_ready drops only when both are full.
// Reset (synchronous, active high) empties both registers, restores pins to 11,
// clears counts, pending total and half mode, and reloads pending_limit (20) and
// stop_ticks (60). Registers sit on the csr_ APB port at byte addresses 0 and 4
// and should be written only while the block is idle.
`default_nettype none

module quadrature_detent_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // sample channel
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_pin_a,
   input  wire logic                              req_pin_b,
   input  wire logic                              req_take,
   // result channel
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [1:0]                        rsp_turn,
   output      logic signed [7:0]                 rsp_pending_after,
   output      logic                              rsp_half_mode,
   // register port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [qdd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [qdd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [qdd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                              csr_pready
);

   // configuration registers
   logic [6:0] pending_limit_ff;
   logic [7:0] stop_ticks_ff;

   // input register
   logic       in_vld_ff;
   logic       pin_a_ff;
   logic       pin_b_ff;
   logic       take_ff;

   // tracking state
   logic [1:0]        last_pins_ff, last_pins_in;
   logic signed [7:0] move_ff, move_in;
   logic [7:0]        stable_ff, stable_in;
   logic              half_ff, half_in;
   logic signed [7:0] pending_ff, pending_in;

   // result register
   logic                  out_vld_ff;
   qdd_pkg::turn_type     turn_ff, turn_in;

   logic advance;

   // decode signals
   logic [1:0]        cur;
   logic              same;
   logic [7:0]        stable_inc;
   logic signed [1:0] step;
   logic signed [8:0] move_sum;
   logic signed [7:0] move_sat;
   logic              rest;
   logic              neg;
   logic [7:0]        mag;
   logic [7:0]        round_mag;
   logic signed [8:0] detents;
   logic signed [8:0] pend_sum;
   logic signed [8:0] lim9;
   logic signed [7:0] pend_upd;

   // register port: always ready, write on access phase
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_limit_ff <= qdd_pkg::PENDING_LIMIT_RESET;
         stop_ticks_ff    <= qdd_pkg::STOP_TICKS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            qdd_pkg::REG_PENDING_LIMIT: pending_limit_ff <= csr_pwdata[6:0];
            qdd_pkg::REG_STOP_TICKS:    stop_ticks_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[2])
         qdd_pkg::REG_PENDING_LIMIT: csr_prdata = {25'd0, pending_limit_ff};
         qdd_pkg::REG_STOP_TICKS:    csr_prdata = {24'd0, stop_ticks_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // flow control: a sample moves on when the result register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pin_a_ff <= req_pin_a;
         pin_b_ff <= req_pin_b;
         take_ff  <= req_take;
      end
   end

   // pin change and stable time
   always_comb begin
      cur        = {pin_a_ff, pin_b_ff};
      same       = (cur == last_pins_ff);
      stable_inc = (stable_ff == 8'hFF) ? 8'hFF : stable_ff + 8'd1;
      half_in    = half_ff | (same && (cur == qdd_pkg::PINS_REST_LOW)
                              && (stable_inc == stop_ticks_ff));
      stable_in  = same ? stable_inc : 8'd0;
      last_pins_in = cur;
   end

   // movement count with saturation at +/-127
   always_comb begin
      step     = qdd_pkg::STEP_TABLE[{last_pins_ff, cur}];
      move_sum = {move_ff[7], move_ff} + {{7{step[1]}}, step};
      if (move_sum > 9'sd127) begin
         move_sat = 8'sd127;
      end else if (move_sum < -9'sd127) begin
         move_sat = -8'sd127;
      end else begin
         move_sat = move_sum[7:0];
      end
      rest = !same && ((cur == qdd_pkg::PINS_REST_HIGH)
                       || ((cur == qdd_pkg::PINS_REST_LOW) && half_ff));
      if (rest) begin
         move_in = 8'sd0;
      end else if (same) begin
         move_in = move_ff;
      end else begin
         move_in = move_sat;
      end
   end

   // round to detents, half away from zero on the magnitude
   always_comb begin
      neg       = move_sat[7];
      mag       = neg ? 8'(-move_sat) : move_sat;
      round_mag = half_ff ? ((mag + 8'd1) >> 1) : ((mag + 8'd2) >> 2);
      detents   = neg ? -$signed({1'b0, round_mag}) : $signed({1'b0, round_mag});
   end

   // on arrival at a rest position, add to pending total and clamp to the limit
   always_comb begin
      pend_sum = detents + {pending_ff[7], pending_ff};
      lim9     = $signed({2'b00, pending_limit_ff});
      if (!rest) begin
         pend_upd = pending_ff;
      end else if (pend_sum > lim9) begin
         pend_upd = lim9[7:0];
      end else if (pend_sum < -lim9) begin
         pend_upd = 8'(-lim9);
      end else begin
         pend_upd = pend_sum[7:0];
      end
   end

   // take one detent after the update
   always_comb begin
      pending_in = pend_upd;
      turn_in    = qdd_pkg::TURN_NONE;
      if (take_ff && (pend_upd > 8'sd0)) begin
         pending_in = pend_upd - 8'sd1;
         turn_in    = qdd_pkg::TURN_RIGHT;
      end else if (take_ff && (pend_upd < 8'sd0)) begin
         pending_in = pend_upd + 8'sd1;
         turn_in    = qdd_pkg::TURN_LEFT;
      end
   end

   // tracking state, updated once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff <= qdd_pkg::PINS_REST_HIGH;
         move_ff      <= 8'sd0;
         stable_ff    <= 8'd0;
         half_ff      <= 1'b0;
         pending_ff   <= 8'sd0;
      end else if (advance) begin
         last_pins_ff <= last_pins_in;
         move_ff      <= move_in;
         stable_ff    <= stable_in;
         half_ff      <= half_in;
         pending_ff   <= pending_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         turn_ff <= turn_in;
      end
   end

   // pending total and mode are the state itself after the sample
   assign rsp_valid         = out_vld_ff;
   assign rsp_turn          = turn_ff;
   assign rsp_pending_after = pending_ff;
   assign rsp_half_mode     = half_ff;

   // half mode never clears once latched
   a_half_sticky: assert property (@(posedge clock) disable iff (reset)
      half_ff |=> half_ff)
      else $error("half mode cleared");

   // pending total never reaches -128
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff != -8'sd128)
      else $error("pending total out of range");

   // movement count stays within +/-127
   a_move_range: assert property (@(posedge clock) disable iff (reset)
      move_ff != -8'sd128)
      else $error("movement count out of range");

   // input side stalls only when both registers are full and output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && out_vld_ff && !rsp_ready))
      else $error("input stalled without cause");

   // a right turn leaves the total one below a positive value
   a_turn_right: assert property (@(posedge clock) disable iff (reset)
      (advance && turn_in == qdd_pkg::TURN_RIGHT) |=> (pending_ff >= 8'sd0))
      else $error("right turn with negative total");

endmodule

`default_nettype wire

// ===== sim/quadrature_detent_decoder_tb.sv =====
// self-checking testbench for the quadrature detent decoder: random pin streams against a predictor
`timescale 1ns / 1ps

// predicts one detent report per sample and checks the reports in order
class detent_scoreboard;
   typedef struct {
      qdd_pkg::turn_type turn;
      logic signed [7:0] total;
      logic              half;
   } detent_report_type;

   detent_report_type expected_reports[$];
   int unsigned       errors;
   // register copy
   logic [6:0]        pending_limit;
   logic [7:0]        stop_ticks;
   // decoder state copy
   logic [1:0]        last_pins;
   logic signed [7:0] move_count;
   logic [7:0]        stable_time;
   logic              half_flag;
   logic signed [7:0] pending_total;

   function new();
      errors        = 0;
      pending_limit = qdd_pkg::PENDING_LIMIT_RESET;
      stop_ticks    = qdd_pkg::STOP_TICKS_RESET;
      last_pins     = qdd_pkg::PINS_REST_HIGH;
      move_count    = '0;
      stable_time   = '0;
      half_flag     = 1'b0;
      pending_total = '0;
   endfunction

   function void set_register(logic idx, logic [31:0] value);
      if (idx == qdd_pkg::REG_PENDING_LIMIT) pending_limit = value[6:0];
      else stop_ticks = value[7:0];
   endfunction

   // position around the gray cycle 00 -> 10 -> 11 -> 01, forward is +1
   function int phase_of(logic [1:0] pins);
      case (pins)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   // round to nearest detent, halves away from zero
   function int round_to_detents(int count, int shift);
      int bias;
      bias = 1 << (shift - 1);
      if (count > 0) return (count + bias) >> shift;
      if (count < 0) return -((-count + bias) >> shift);
      return 0;
   endfunction

   task report(string what, int got, int want);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch on %s: got %0d, expected %0d",
                                 $time, what, got, want);
   endtask

   function void note_sample(logic pin_a, logic pin_b, logic take);
      logic [1:0]        pins;
      int                diff;
      int                count;
      int                detents;
      detent_report_type want;
      pins      = {pin_a, pin_b};
      want.turn = qdd_pkg::TURN_NONE;
      if (pins == last_pins) begin
         // resting: stable time counts, long rest at 00 latches half mode
         if (stable_time != 8'd255) stable_time = stable_time + 8'd1;
         if (pins == qdd_pkg::PINS_REST_LOW && stable_time == stop_ticks) half_flag = 1'b1;
      end else begin
         // a quarter step moves the count, a jump across the cycle adds nothing
         diff  = (phase_of(pins) - phase_of(last_pins)) & 3;
         count = int'(move_count) + (diff == 1 ? 1 : diff == 3 ? -1 : 0);
         if (count > 127) count = 127;
         if (count < -127) count = -127;
         last_pins   = pins;
         stable_time = '0;
         // arrival at a rest position folds the count into the pending total
         if (pins == qdd_pkg::PINS_REST_HIGH
             || (pins == qdd_pkg::PINS_REST_LOW && half_flag)) begin
            detents = round_to_detents(count, half_flag ? 1 : 2) + int'(pending_total);
            if (detents > int'(pending_limit)) detents = int'(pending_limit);
            if (detents < -int'(pending_limit)) detents = -int'(pending_limit);
            pending_total = 8'(detents);
            count = 0;
         end
         move_count = 8'(count);
      end
      // take pops one detent after the update
      if (take) begin
         if (pending_total > 0) begin
            pending_total = pending_total - 8'sd1;
            want.turn     = qdd_pkg::TURN_RIGHT;
         end else if (pending_total < 0) begin
            pending_total = pending_total + 8'sd1;
            want.turn     = qdd_pkg::TURN_LEFT;
         end
      end
      want.total = pending_total;
      want.half  = half_flag;
      expected_reports.push_back(want);
   endfunction

   task check_result(logic [1:0] turn, logic signed [7:0] total, logic half);
      detent_report_type want;
      if (expected_reports.size() == 0) begin
         report("report with nothing outstanding", turn, 0);
         return;
      end
      want = expected_reports.pop_front();
      if (turn !== want.turn) report("turn", turn, want.turn);
      if (total !== want.total) report("pending total", total, want.total);
      if (half !== want.half) report("half mode", half, want.half);
   endtask
endclass

module quadrature_detent_decoder_tb;

   localparam int CYCLE_LIMIT = 400000;

   // sample bits {pin_a, pin_b, take} for the opening sequence
   localparam logic [2:0] OPENING_TICKS [21] = '{
      3'b111,                                  // take with nothing pending
      3'b010, 3'b000, 3'b100, 3'b110,          // one detent right
      3'b111,                                  // take it
      3'b100, 3'b000, 3'b010, 3'b111,          // one detent left, taken on arrival
      3'b000, 3'b000, 3'b000, 3'b000, 3'b110,  // jumps across and a short rest at 00
      3'b010, 3'b110,                          // half step out and back
      3'b010, 3'b100, 3'b110,                  // bounce in the middle, rounds up to one
      3'b111
   };

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_valid   = 1'b0;
   logic                           req_ready;
   logic                           req_pin_a   = 1'b1;
   logic                           req_pin_b   = 1'b1;
   logic                           req_take    = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready   = 1'b0;
   logic [1:0]                     rsp_turn;
   logic signed [7:0]              rsp_pending_after;
   logic                           rsp_half_mode;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [qdd_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [qdd_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [qdd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   detent_scoreboard sb = new();
   logic [1:0]       cur_pins    = qdd_pkg::PINS_REST_HIGH;
   bit               quiet       = 1'b0;
   int               take_pct    = 25;
   int               items_sent  = 0;
   int               cycle_count = 0;

   quadrature_detent_decoder i_dut (.*);

   always #6 clock = ~clock;

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_turn, rsp_pending_after, rsp_half_mode);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 93) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   // result side back-pressure
   initial begin : result_sink
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready = 1'b0;
         end else if (quiet || $urandom_range(0, 4) != 0) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b0;
            hold      = gap_length() - 1;
         end
      end
   end

   function automatic logic [1:0] pins_at(int phase);
      case (phase & 3)
         0:       return qdd_pkg::PINS_REST_LOW;
         1:       return 2'b10;
         2:       return qdd_pkg::PINS_REST_HIGH;
         default: return 2'b01;
      endcase
   endfunction

   function automatic logic take_draw();
      return $urandom_range(0, 99) < take_pct;
   endfunction

   function automatic bit at_rest();
      return cur_pins == qdd_pkg::PINS_REST_HIGH
             || (sb.half_flag && cur_pins == qdd_pkg::PINS_REST_LOW);
   endfunction

   // one sample transfer, valid held until accepted
   task automatic send_pins(input logic [1:0] pins, input logic take_req);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) >= 60) ? gap_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pin_a = pins[1];
      req_pin_b = pins[0];
      req_take  = take_req;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(pins[1], pins[0], take_req);
      cur_pins = pins;
      items_sent++;
   endtask

   // drop valid and let every outstanding report drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic idx, input logic is_write, input logic [31:0] value,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic verify_register(input logic idx, input logic [31:0] want);
      logic [31:0] readback;
      csr_access(idx, 1'b0, '0, readback);
      if (readback !== want) sb.report("register readback", readback, want);
   endtask

   task automatic configure(input logic [31:0] limit, input logic [31:0] stop);
      logic [31:0] unused;
      wait_idle();
      csr_access(qdd_pkg::REG_PENDING_LIMIT, 1'b1, limit, unused);
      sb.set_register(qdd_pkg::REG_PENDING_LIMIT, limit);
      verify_register(qdd_pkg::REG_PENDING_LIMIT, limit);
      csr_access(qdd_pkg::REG_STOP_TICKS, 1'b1, stop, unused);
      sb.set_register(qdd_pkg::REG_STOP_TICKS, stop);
      verify_register(qdd_pkg::REG_STOP_TICKS, stop);
   endtask

   // one quarter step, sometimes resting a few ticks on the new position
   task automatic step_once(input int dir);
      send_pins(pins_at(sb.phase_of(cur_pins) + dir), take_draw());
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) send_pins(cur_pins, take_draw());
   endtask

   task automatic walk_to_rest(input int dir, input int min_steps);
      int n;
      n = 0;
      while (n < min_steps || !at_rest()) begin
         step_once(dir);
         n++;
      end
   endtask

   // mostly clean turns with random takes, plus jitter, bounces and drains
   task automatic random_traffic(input int amount);
      int start;
      int kind;
      int dir;
      int m;
      int loops;
      start = items_sent;
      while (items_sent - start < amount) begin
         quiet = ($urandom_range(0, 5) == 0);
         kind  = $urandom_range(0, 99);
         dir   = $urandom_range(0, 1) ? 1 : -1;
         if (kind < 45) begin
            walk_to_rest(dir, 4 * $urandom_range(1, 3));
         end else if (kind < 60) begin
            m = $urandom_range(1, 2);
            repeat (m) step_once(dir);
            repeat (m) step_once(-dir);
         end else if (kind < 72) begin
            repeat ($urandom_range(1, 6)) send_pins(2'($urandom_range(0, 3)), take_draw());
         end else if (kind < 84) begin
            repeat ($urandom_range(1, 5)) send_pins(cur_pins, 1'b1);
         end else if (kind < 96 && !sb.half_flag) begin
            // climb the count through 00, 10 and 01 without reaching a rest position
            while (cur_pins != qdd_pkg::PINS_REST_LOW) step_once(dir);
            loops = ($urandom_range(0, 2) == 0) ? $urandom_range(45, 70) : $urandom_range(1, 5);
            repeat (loops) begin
               send_pins(pins_at(dir), take_draw());
               send_pins(pins_at(-dir), take_draw());
               send_pins(qdd_pkg::PINS_REST_LOW, take_draw());
            end
            step_once(dir);
            step_once(dir);
         end else if (kind < 96) begin
            walk_to_rest(dir, 2);
         end else begin
            wait_idle();
         end
      end
      quiet = 1'b0;
   endtask

   initial begin : stimulus
      int i;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      verify_register(qdd_pkg::REG_PENDING_LIMIT, 32'(qdd_pkg::PENDING_LIMIT_RESET));
      verify_register(qdd_pkg::REG_STOP_TICKS, 32'(qdd_pkg::STOP_TICKS_RESET));

      // opening sequence at reset settings
      for (i = 0; i < 21; i++) send_pins(OPENING_TICKS[i][2:1], OPENING_TICKS[i][0]);

      // tightest limit, full-cycle detents
      configure(1, 255);
      random_traffic(160);

      // build up a total, then lower the limit under it
      configure(127, 255);
      take_pct = 0;
      repeat (12) walk_to_rest(1, 4);
      configure(3, 255);
      repeat (4) send_pins(cur_pins, 1'b1);
      walk_to_rest(1, 4);
      take_pct = 25;
      configure(127, 255);
      random_traffic(230);

      // rest at 00 one tick short of the stop time
      send_pins(pins_at(1), 1'b0);
      send_pins(qdd_pkg::PINS_REST_LOW, 1'b0);
      repeat (254) send_pins(qdd_pkg::PINS_REST_LOW, take_draw());

      // shortest stop time latches half mode on the first repeat
      configure($urandom_range(2, 126), 1);
      send_pins(pins_at(1), 1'b0);
      send_pins(qdd_pkg::PINS_REST_LOW, 1'b0);
      send_pins(qdd_pkg::PINS_REST_LOW, 1'b1);
      random_traffic(80);
      configure(1, $urandom_range(2, 254));
      random_traffic(80);
      configure(127, $urandom_range(2, 254));
      random_traffic(80);

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
